// ===== sv/qpht_pkg.sv =====
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared constants, codes and types of the quadratic probe hash table.
// ----------------------------------------------------------------------------
package qpht_pkg;

  // Default sizing of the table.
  localparam int unsigned DEF_TABLE_SLOTS = 128;
  localparam int unsigned DEF_KEY_BYTES   = 11;
  localparam int unsigned DEF_HANDLE_BITS = 16;

  // Fixed field widths of the channels.
  localparam int unsigned OP_BITS         = 1;
  localparam int unsigned KEY_HEAD_BITS   = 64;
  localparam int unsigned KEY_TAIL_BITS   = 24;
  localparam int unsigned FULL_KEY_BITS   = KEY_HEAD_BITS + KEY_TAIL_BITS;
  localparam int unsigned FULL_KEY_BYTES  = FULL_KEY_BITS / 8;
  localparam int unsigned LEN_BITS        = 4;
  localparam int unsigned IO_HANDLE_BITS  = 16;
  localparam int unsigned STATUS_BITS     = 2;
  localparam int unsigned SLOT_INDEX_BITS = 7;

  // Hash constants.
  localparam int unsigned      HASH_MULT    = 37;
  localparam logic [31:0]      HASH_INT_MIN = 32'h8000_0000;

  // Operation codes.
  localparam logic [OP_BITS-1:0] OP_INSERT = 1'b0;
  localparam logic [OP_BITS-1:0] OP_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] STATUS_STORED  = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FOUND   = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_MISSING = 2'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_DROPPED = 2'd3;

  // Main controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOME,
    ST_ISSUE,
    ST_CHECK
  } qpht_state_t;

  // Home slot unit states.
  typedef enum logic [1:0] {
    HS_IDLE,
    HS_HASH,
    HS_MOD,
    HS_DONE
  } qpht_home_state_t;

  // Status of the home slot unit toward the controller.
  typedef struct packed {
    logic done;
    logic fail;
  } qpht_home_sts_t;

endpackage

// ===== sv/qpht_in_if.sv =====
// ----------------------------------------------------------------------------
// qpht_in_if
// Request channel: one item is an insert or a lookup with its key.
// ----------------------------------------------------------------------------
interface qpht_in_if import qpht_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_BITS-1:0]        operation;
  logic [KEY_HEAD_BITS-1:0]  key_head;
  logic [KEY_TAIL_BITS-1:0]  key_tail;
  logic [LEN_BITS-1:0]       key_length;
  logic [IO_HANDLE_BITS-1:0] record_handle;

  modport source (
    output valid, operation, key_head, key_tail, key_length, record_handle,
    input  ready
  );

  modport sink (
    input  valid, operation, key_head, key_tail, key_length, record_handle,
    output ready
  );
endinterface

// ===== sv/qpht_out_if.sv =====
// ----------------------------------------------------------------------------
// qpht_out_if
// Result channel: one item per request with status, handle and slot.
// ----------------------------------------------------------------------------
interface qpht_out_if import qpht_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_BITS-1:0]     status;
  logic [IO_HANDLE_BITS-1:0]  found_handle;
  logic [SLOT_INDEX_BITS-1:0] slot_index;

  modport source (
    output valid, status, found_handle, slot_index,
    input  ready
  );

  modport sink (
    input  valid, status, found_handle, slot_index,
    output ready
  );
endinterface

// ===== sv/qpht_home.sv =====
// ----------------------------------------------------------------------------
// qpht_home
// Home slot unit: byte-serial multiplicative hash, magnitude, and a
// reciprocal-multiply remainder by the slot count (a mask for a power of two).
// ----------------------------------------------------------------------------
module qpht_home import qpht_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [FULL_KEY_BITS-1:0]         key_in,
  input  logic [LEN_BITS-1:0]              len_in,
  output qpht_home_sts_t                   sts,
  output logic [$clog2(TABLE_SLOTS)-1:0]   home
);

  localparam int unsigned IDX_W    = $clog2(TABLE_SLOTS);
  localparam bit          IS_POW2  = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam logic [IDX_W:0] SLOTS_EXT = (IDX_W + 1)'(TABLE_SLOTS);
  // floor(2^31 / slots). With a magnitude below 2^31 the quotient estimate
  // is low by at most one, so one compare and subtract finishes the job.
  localparam logic [31:0]    RECIP     = 32'((64'd1 << 31) / 64'(TABLE_SLOTS));

  qpht_home_state_t         hst_r, hst_nxt;
  logic [FULL_KEY_BITS-1:0] shf_r, shf_nxt;
  logic [LEN_BITS-1:0]      cnt_r, cnt_nxt;
  logic [LEN_BITS-1:0]      len_r, len_nxt;
  logic [31:0]              hash_r, hash_nxt;
  logic [31:0]              mag_r, mag_nxt;
  logic                     phase_r, phase_nxt;
  logic [63:0]              prod_r, prod_nxt;
  logic [IDX_W-1:0]         rem_r, rem_nxt;
  logic                     fail_r, fail_nxt;
  logic [IDX_W:0]           qn_low;
  logic [IDX_W:0]           rem_est;

  // Next state.
  always_comb begin
    hst_nxt = hst_r;
    case (hst_r)
      HS_IDLE: begin
        if (start) hst_nxt = HS_HASH;
      end
      HS_HASH: begin
        if (cnt_r == len_r) begin
          hst_nxt = (hash_r == HASH_INT_MIN) ? HS_DONE : HS_MOD;
        end
      end
      HS_MOD: begin
        if (IS_POW2 || phase_r) hst_nxt = HS_DONE;
      end
      HS_DONE: begin
        if (start) hst_nxt = HS_HASH;
      end
      default: hst_nxt = HS_IDLE;
    endcase
    if (start) hst_nxt = HS_HASH;
  end

  // Datapath and outputs.
  always_comb begin
    shf_nxt   = shf_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    hash_nxt  = hash_r;
    mag_nxt   = mag_r;
    phase_nxt = phase_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    fail_nxt  = fail_r;
    // Only the low bits of quotient times slots matter: the estimate of the
    // remainder is below twice the slot count.
    qn_low    = prod_r[31 +: IDX_W + 1] * SLOTS_EXT;
    rem_est   = mag_r[IDX_W:0] - qn_low;
    if (start) begin
      shf_nxt  = key_in;
      cnt_nxt  = '0;
      len_nxt  = len_in;
      hash_nxt = '0;
      fail_nxt = 1'b0;
    end else begin
      case (hst_r)
        HS_HASH: begin
          if (cnt_r != len_r) begin
            hash_nxt = 32'(hash_r * 32'(HASH_MULT)) +
                       32'(shf_r[FULL_KEY_BITS-1 -: 8]);
            shf_nxt  = shf_r << 8;
            cnt_nxt  = cnt_r + LEN_BITS'(1);
          end else begin
            fail_nxt  = (hash_r == HASH_INT_MIN);
            mag_nxt   = hash_r[31] ? (32'd0 - hash_r) : hash_r;
            phase_nxt = 1'b0;
            rem_nxt   = '0;
          end
        end
        HS_MOD: begin
          if (IS_POW2) begin
            rem_nxt = mag_r[IDX_W-1:0];
          end else if (!phase_r) begin
            prod_nxt  = 64'(mag_r) * 64'(RECIP);
            phase_nxt = 1'b1;
          end else begin
            rem_nxt = (rem_est >= SLOTS_EXT) ? IDX_W'(rem_est - SLOTS_EXT) : IDX_W'(rem_est);
          end
        end
        default: ;
      endcase
    end
    sts.done = (hst_r == HS_DONE);
    sts.fail = fail_r;
    home     = rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hst_r <= HS_IDLE;
    end else begin
      hst_r <= hst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shf_r   <= shf_nxt;
    cnt_r   <= cnt_nxt;
    len_r   <= len_nxt;
    hash_r  <= hash_nxt;
    mag_r   <= mag_nxt;
    phase_r <= phase_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    fail_r  <= fail_nxt;
  end

endmodule

// ===== sv/quadratic_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressed hash table with quadratic probing over one slot memory.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Item contents
//   in_chan   sink       operation, key_head, key_tail, key_length, record_handle
//   out_chan  source     status, found_handle, slot_index
//
// After reset the block sweeps the slot memory once to clear every valid
// flag; no item is accepted meanwhile. One item is handled at a time. The
// hash consumes one key byte per cycle, and each probe is a memory read
// followed by a check of the registered entry. A slot count that is not a
// power of two adds a reciprocal-multiply step for the remainder. The
// finished result sits in an output register, so a new item is taken while
// the previous result waits; the controller only stalls when a second
// result is ready before the first has been taken.
//
// The hash starts at zero and becomes hash * 37 + byte for every key byte,
// wrapping at 32 bits. Its magnitude modulo the slot count is the home slot.
// The most negative hash has no magnitude, so such an item fails at once.
// Probes go home, home+1, home-1, home+4, home-4, and so on, and the first
// probe outside the table ends the search. Insert takes the first empty
// probed slot; lookup takes the first occupied slot with an equal key.
//
module quadratic_probe_hash_table import qpht_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int unsigned KEY_BYTES   = DEF_KEY_BYTES,
  parameter int unsigned HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  qpht_in_if.sink     in_chan,
  qpht_out_if.source  out_chan
);

  localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
  localparam int unsigned KEY_W = 8 * KEY_BYTES;

  // One slot of the table.
  typedef struct packed {
    logic                   valid;
    logic [LEN_BITS-1:0]    len;
    logic [KEY_W-1:0]       key;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  entry_t slot_mem [TABLE_SLOTS];
  entry_t rd_q;

  qpht_state_t            state_r, state_nxt;
  logic [IDX_W-1:0]       clr_r;
  logic [OP_BITS-1:0]     op_r;
  logic [KEY_W-1:0]       key_r;
  logic [LEN_BITS-1:0]    len_r;
  logic [HANDLE_BITS-1:0] hnd_r;
  logic [IDX_W-1:0]       home_r;
  logic [IDX_W-1:0]       j_r;
  logic [IDX_W:0]         sq_r;
  logic                   side_r;
  logic [IDX_W-1:0]       idx_r;

  logic                       out_valid_r;
  logic [STATUS_BITS-1:0]     out_status_r;
  logic [IO_HANDLE_BITS-1:0]  out_handle_r;
  logic [SLOT_INDEX_BITS-1:0] out_slot_r;

  // Input canonicalization: saturated length, bytes past it forced to zero.
  logic [FULL_KEY_BITS-1:0] key_raw;
  logic [FULL_KEY_BITS-1:0] key_cn;
  logic [LEN_BITS-1:0]      len_sat;

  // Home slot unit link.
  qpht_home_sts_t   hsts;
  logic [IDX_W-1:0] hhome;
  logic             in_fire;

  // Probe candidate and entry checks.
  logic [IDX_W+1:0] cand;
  logic             cand_out;
  logic             ent_match;
  logic             hit;
  logic             out_free;
  logic [STATUS_BITS-1:0] miss_code;

  // Controller outputs.
  logic                       emit;
  logic [STATUS_BITS-1:0]     emit_status;
  logic [IO_HANDLE_BITS-1:0]  emit_handle;
  logic [SLOT_INDEX_BITS-1:0] emit_slot;
  logic                       rd_en;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  entry_t                     wr_data;
  logic                       probe_load;
  logic                       probe_adv;

  assign key_raw = {in_chan.key_head, in_chan.key_tail};
  assign len_sat = (in_chan.key_length > LEN_BITS'(KEY_BYTES)) ?
                   LEN_BITS'(KEY_BYTES) : in_chan.key_length;

  always_comb begin
    for (int k = 0; k < FULL_KEY_BYTES; k++) begin
      key_cn[FULL_KEY_BITS-1-8*k -: 8] = (k < int'(len_sat)) ?
                                         key_raw[FULL_KEY_BITS-1-8*k -: 8] : 8'd0;
    end
  end

  assign in_fire = in_chan.valid && in_chan.ready;

  qpht_home #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_home (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_fire),
    .key_in (key_cn),
    .len_in (len_sat),
    .sts    (hsts),
    .home   (hhome)
  );

  // The candidate index is home plus or minus the current square. A set top
  // bit means the subtraction went below zero or the sum is far past the end.
  assign cand     = side_r ? ({2'b00, home_r} - {1'b0, sq_r})
                           : ({2'b00, home_r} + {1'b0, sq_r});
  assign cand_out = cand[IDX_W+1] || (cand >= (IDX_W + 2)'(TABLE_SLOTS));

  assign ent_match = rd_q.valid && (rd_q.len == len_r) && (rd_q.key == key_r);
  assign hit       = (op_r == OP_INSERT) ? !rd_q.valid : ent_match;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign miss_code = (op_r == OP_LOOKUP) ? STATUS_MISSING : STATUS_DROPPED;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == IDX_W'(TABLE_SLOTS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_HOME;
      end
      ST_HOME: begin
        if (hsts.done) begin
          if (!hsts.fail) begin
            state_nxt = ST_ISSUE;
          end else if (out_free) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ISSUE: begin
        if (!cand_out) begin
          state_nxt = ST_CHECK;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (!hit) begin
          state_nxt = ST_ISSUE;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_chan.ready = (state_r == ST_IDLE);
    emit          = 1'b0;
    emit_status   = STATUS_STORED;
    emit_handle   = '0;
    emit_slot     = '0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = '0;
    probe_load    = 1'b0;
    probe_adv     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
      end
      ST_HOME: begin
        if (hsts.done) begin
          if (!hsts.fail) begin
            probe_load = 1'b1;
          end else if (out_free) begin
            emit        = 1'b1;
            emit_status = miss_code;
          end
        end
      end
      ST_ISSUE: begin
        if (!cand_out) begin
          rd_en = 1'b1;
        end else if (out_free) begin
          emit        = 1'b1;
          emit_status = miss_code;
        end
      end
      ST_CHECK: begin
        if (!hit) begin
          probe_adv = 1'b1;
        end else if (out_free) begin
          emit      = 1'b1;
          emit_slot = SLOT_INDEX_BITS'(idx_r);
          if (op_r == OP_INSERT) begin
            emit_status    = STATUS_STORED;
            wr_en          = 1'b1;
            wr_data.valid  = 1'b1;
            wr_data.len    = len_r;
            wr_data.key    = key_r;
            wr_data.handle = hnd_r;
          end else begin
            emit_status = STATUS_FOUND;
            emit_handle = IO_HANDLE_BITS'(rd_q.handle);
          end
        end
      end
      default: ;
    endcase
  end

  // Slot memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) slot_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= slot_mem[cand[IDX_W-1:0]];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + IDX_W'(1);
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and probe registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_chan.operation;
      key_r <= key_cn[FULL_KEY_BITS-1 -: KEY_W];
      len_r <= len_sat;
      hnd_r <= HANDLE_BITS'(in_chan.record_handle);
    end
    if (probe_load) begin
      home_r <= hhome;
      j_r    <= '0;
      sq_r   <= '0;
      side_r <= 1'b0;
    end else if (probe_adv) begin
      // The home slot has a single probe; later squares go plus, then minus.
      if (!side_r && j_r != '0) begin
        side_r <= 1'b1;
      end else begin
        side_r <= 1'b0;
        j_r    <= j_r + IDX_W'(1);
        sq_r   <= sq_r + {j_r, 1'b1};
      end
    end
    if (rd_en) idx_r <= cand[IDX_W-1:0];
    if (emit) begin
      out_status_r <= emit_status;
      out_handle_r <= emit_handle;
      out_slot_r   <= emit_slot;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.found_handle = out_handle_r;
  assign out_chan.slot_index   = out_slot_r;

endmodule
